// File: sv/sfpa_pkg.sv
// Shared constants, command codes, divider stage record and saturation helpers.
`default_nettype none
package sfpa_pkg;

  // fixed-point scale, legal range 2 .. 2**30
  localparam int unsigned SCALE = 65536;
  localparam logic signed [31:0] SCALE_S = 32'(SCALE);

  localparam int unsigned DIV_STEPS = 32;

  localparam logic signed [31:0] I32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CMD_FROM_INT = 3'd0,
    CMD_NEGATE   = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUBTRACT = 3'd3,
    CMD_MULTIPLY = 3'd4,
    CMD_DIVIDE   = 3'd5
  } cmd_t;

  // one slot of the restoring divider pipeline
  typedef struct packed {
    logic        valid;
    logic        use_div;
    logic        neg;
    logic        ovf;
    logic [31:0] rem;
    logic [31:0] lo;      // dividend bits not yet consumed, quotient bits shift in
    logic [31:0] dvs;
    logic [31:0] simple;  // result of the non-dividing commands
  } div_rec_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(I32_MAX)) begin
      r = I32_MAX;
    end else if (v < 64'(I32_MIN)) begin
      r = I32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // 33-bit sum: overflow when the top two bits differ
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? I32_MIN : I32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/sfpa_divider.sv
// Unsigned 64-by-32 restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module sfpa_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire sfpa_pkg::div_rec_t din,
  output sfpa_pkg::div_rec_t      dout
);
  import sfpa_pkg::*;

  div_rec_t stg [1:DIV_STEPS];

  function automatic div_rec_t div_step(input div_rec_t s);
    div_rec_t    r;
    logic [32:0] t;
    logic        ge;
    r  = s;
    t  = {s.rem, s.lo[31]};
    ge = (t >= {1'b0, s.dvs});
    r.rem = ge ? 32'(t - {1'b0, s.dvs}) : t[31:0];
    r.lo  = {s.lo[30:0], ge};
    return r;
  endfunction

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_rec_t prev;
    if (k == 0) begin : g_first
      assign prev = din;
    end else begin : g_rest
      assign prev = stg[k];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else if (en) begin
        stg[k+1] <= div_step(prev);
      end
    end
  end

  assign dout = stg[DIV_STEPS];

endmodule
`default_nettype wire

// File: sv/saturating_fixed_point_alu_top.sv
// Saturating fixed-point ALU: multiplier front end, shared divider pipeline, saturation stage.
//
// Input stream: s_tdata carries operand_a [31:0] and operand_b [63:32], both signed raw
// fixed-point values; s_tuser carries the command (from_int, negate, add, subtract,
// multiply, divide). A transfer happens when tvalid and tready are both high.
// Output stream: m_tdata carries the 32-bit saturated raw result, one per input.
// Every command passes the same registers in order: the 32x32 multiplier and the
// add/subtract unit, magnitude and overflow detection, the one-bit-per-stage
// divider, and sign and saturation. multiply divides the product by SCALE and
// divide divides a*SCALE by b in the same divider, so results come out in order.
// Throughput is one item per cycle while the output is not stalled.
// The pipeline advances as a whole: when m_tvalid is high and m_tready is low every
// stage holds and s_tready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits; the block keeps no other state.
`default_nettype none
module saturating_fixed_point_alu_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  wire logic [2:0]  s_tuser,   // command [2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata    // result [31:0]
);
  import sfpa_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 0: multiplier and add/subtract
  logic signed [31:0] a_in, b_in, rhs;
  logic signed [63:0] prod_next;
  logic signed [31:0] simple_next;
  cmd_t               cmd_in;

  assign a_in   = s_tdata[31:0];
  assign b_in   = s_tdata[63:32];
  assign cmd_in = cmd_t'(s_tuser);
  assign rhs    = (cmd_in == CMD_MULTIPLY) ? b_in : SCALE_S;
  assign prod_next = a_in * rhs;

  always_comb begin
    case (cmd_in)
      CMD_NEGATE:   simple_next = sat33(-{a_in[31], a_in});
      CMD_ADD:      simple_next = sat33({a_in[31], a_in} + {b_in[31], b_in});
      CMD_SUBTRACT: simple_next = sat33({a_in[31], a_in} - {b_in[31], b_in});
      default:      simple_next = '0;
    endcase
  end

  logic               s0_valid;
  cmd_t               s0_cmd;
  logic signed [63:0] s0_prod;
  logic signed [31:0] s0_b;
  logic signed [31:0] s0_simple;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_cmd    <= cmd_in;
      s0_prod   <= prod_next;
      s0_b      <= b_in;
      s0_simple <= simple_next;
    end
  end

  // stage 1: magnitudes, quotient sign, quotient >= 2**32 check
  logic signed [31:0] dv;
  logic [63:0]        num_mag;
  logic [31:0]        dv_mag;
  div_rec_t           s1_next, s1, dq;

  assign dv      = (s0_cmd == CMD_DIVIDE) ? s0_b : SCALE_S;
  assign num_mag = s0_prod[63] ? 64'(-s0_prod) : 64'(s0_prod);
  assign dv_mag  = dv[31] ? 32'(-dv) : 32'(dv);

  always_comb begin
    s1_next.valid   = s0_valid;
    s1_next.use_div = (s0_cmd == CMD_MULTIPLY) || (s0_cmd == CMD_DIVIDE);
    s1_next.neg     = s0_prod[63] ^ dv[31];
    // zero divisor always lands here, sign then follows operand_a
    s1_next.ovf     = (num_mag[63:32] >= dv_mag);
    s1_next.rem     = num_mag[63:32];
    s1_next.lo      = num_mag[31:0];
    s1_next.dvs     = dv_mag;
    s1_next.simple  = (s0_cmd == CMD_FROM_INT) ? sat64(s0_prod) : s0_simple;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
    end
  end

  sfpa_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  (s1),
    .dout (dq)
  );

  // final stage: sign and saturation
  logic [31:0] res_next;

  always_comb begin
    if (!dq.use_div) begin
      res_next = dq.simple;
    end else if (dq.ovf) begin
      res_next = dq.neg ? I32_MIN : I32_MAX;
    end else if (dq.neg) begin
      res_next = (dq.lo > 32'h8000_0000) ? I32_MIN : 32'(-dq.lo);
    end else begin
      res_next = (dq.lo > 32'h7fff_ffff) ? I32_MAX : dq.lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dq.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/sfpa_checker.sv
// Port-level assertions for the saturating fixed-point ALU, bound to the top level.
`default_nettype none
module sfpa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // input side opens exactly when the output register can move
  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  a_no_output_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high right after reset");

  // a blocked input means the output is holding a result
  a_block_means_pending: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |-> m_tvalid)
    else $error("input blocked with no pending result");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind saturating_fixed_point_alu_top sfpa_checker u_sfpa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// File: sim/saturating_fixed_point_alu_top_tb.sv
// Testbench for the saturating fixed-point ALU: directed and random commands vs. a predictor.
`default_nettype none
module saturating_fixed_point_alu_top_tb;
  import sfpa_pkg::*;

  localparam int LATENCY = 35;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // operand_a [31:0], operand_b [63:32]
  logic [2:0]  s_tuser = '0;   // command [2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // result [31:0]

  logic signed [31:0] expected_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cmd_count[8];
  bit stall_off = 1'b0;

  saturating_fixed_point_alu_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [63:0] trunc_div(input logic signed [63:0] n,
                                                   input logic signed [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q = un / ud;
    return (n[63] ^ d[63]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] alu_result(input logic [2:0] cmd,
                                                    input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] wa, wb, sc;
    wa = a;
    wb = b;
    sc = 64'(SCALE);
    case (cmd)
      CMD_FROM_INT: return clamp32(wa * sc);
      CMD_NEGATE:   return clamp32(-wa);
      CMD_ADD:      return clamp32(wa + wb);
      CMD_SUBTRACT: return clamp32(wa - wb);
      CMD_MULTIPLY: return clamp32(trunc_div(wa * wb, sc));
      CMD_DIVIDE: begin
        if (b == 0) return (a >= 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
        return clamp32(trunc_div(wa * sc, wb));
      end
      default:      return 32'sd0;
    endcase
  endfunction

  // tvalid stays high between calls; it drops only while an idle gap runs
  task automatic send_op(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(alu_result(cmd, a, b));
    items_sent++;
    cmd_count[cmd]++;
    @(negedge clk);
  endtask

  // receiver: random stalls, sample at rising edge
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = stall_off ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: result=%0d", $signed(m_tdata));
        errors++;
      end else begin
        logic signed [31:0] exp_r;
        exp_r = expected_results.pop_front();
        if (m_tdata !== exp_r) begin
          $error("result mismatch: expected %0d actual %0d", exp_r, $signed(m_tdata));
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h1;
      4: return 32'hffff_ffff;
      5: return $urandom_range(0, 65535);
      6: return -$urandom_range(0, 65535);
      7: return 32'(SCALE);
      8: return $urandom_range(0, 255) << $urandom_range(0, 24);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [2:0] c;
    send_op(CMD_FROM_INT, 32'h7fff_ffff, 32'h0);
    send_op(CMD_FROM_INT, 32'h8000_0000, 32'hffff_ffff);
    send_op(CMD_FROM_INT, 32'hffff_fffd, 32'h0);
    send_op(CMD_NEGATE, 32'h8000_0000, 32'h0);
    send_op(CMD_NEGATE, 32'h7fff_ffff, 32'h0);
    send_op(CMD_ADD, 32'h7fff_ffff, 32'h1);
    send_op(CMD_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_op(CMD_SUBTRACT, 32'h8000_0000, 32'h1);
    send_op(CMD_SUBTRACT, 32'h7fff_ffff, 32'h8000_0000);
    send_op(CMD_MULTIPLY, 32'h8000_0000, 32'h8000_0000);
    send_op(CMD_MULTIPLY, 32'hffff_ffff, 32'h1);       // truncates toward zero
    send_op(CMD_MULTIPLY, 32'h0003_0000, 32'hfffe_8000);
    send_op(CMD_DIVIDE, 32'h0001_0000, 32'h0);          // divide by zero, positive
    send_op(CMD_DIVIDE, 32'h0, 32'h0);
    send_op(CMD_DIVIDE, 32'hffff_ffff, 32'h0);          // divide by zero, negative
    send_op(CMD_DIVIDE, 32'hffff_ffff, 32'h0003_0000);
    send_op(CMD_DIVIDE, 32'h8000_0000, 32'hffff_ffff);
    send_op(CMD_DIVIDE, 32'h7fff_ffff, 32'h1);
    c = 3'd6;
    send_op(c, 32'h1234_5678, 32'h9abc_def0);           // unused codes give zero
    c = 3'd7;
    send_op(c, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      logic [2:0] c;
      logic [31:0] a, b;
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      a = $urandom_range(0, 1) ? edge_value() : $urandom;
      b = $urandom_range(0, 1) ? edge_value() : $urandom;
      send_op(c, a, b);
    end
  endtask

  // back-to-back with the receiver always ready
  task automatic test_full_rate(input int n);
    stall_off = 1'b1;
    for (int i = 0; i < n; i++) begin
      s_tvalid <= 1'b1;
      s_tuser  <= 3'($urandom_range(0, 5));
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      expected_results.push_back(alu_result(s_tuser, s_tdata[31:0], s_tdata[63:32]));
      items_sent++;
      cmd_count[s_tuser]++;
      @(negedge clk);
    end
    s_tvalid <= 1'b0;
    stall_off = 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1000);
    test_full_rate(200);
    drain();
    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("commands 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", cmd_count[0], cmd_count[1],
             cmd_count[2], cmd_count[3], cmd_count[4], cmd_count[5], cmd_count[6],
             cmd_count[7]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
